// ===== rtl/trg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trg_pkg
// shared widths, constants and divider handshake types for the triangle
// rasterizer
// ---------------------------------------------------------------------------
package trg_pkg;

  localparam int CRD_W  = 7;
  localparam int VTX_W  = 12;
  localparam int PT_W   = 13;
  localparam int AREA_W = 28;
  localparam int OPB_W  = 14;
  localparam int PROD_W = AREA_W + OPB_W;
  localparam int NUM_W  = 36;
  localparam int DEN_W  = 28;
  localparam int DSH_W  = DEN_W + 8;
  localparam int CNT_W  = 13;

  localparam logic [31:0]      BLACK_PIXEL = 32'h0100_0000;
  localparam logic [CNT_W-1:0] CNT_MAX     = 13'd8191;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] q;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/trg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trg_ram
// single-port ram with registered read
// ---------------------------------------------------------------------------
module trg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/trg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trg_div
// restoring divider, one quotient bit per cycle, quotient saturated to 255
// ---------------------------------------------------------------------------
module trg_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire trg_pkg::div_req_t req,
  output trg_pkg::div_rsp_t      rsp
);

  logic                      busy;
  logic                      done;
  logic [trg_pkg::NUM_W-1:0] rem;
  logic [trg_pkg::DSH_W-1:0] dsh;
  logic [8:0]                q;
  logic [3:0]                bitc;
  logic                      ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && bitc == 4'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num;
      dsh  <= {req.den, 8'd0};
      q    <= '0;
      bitc <= 4'd8;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q    <= {q[7:0], ge};
      dsh  <= dsh >> 1;
      bitc <= bitc - 4'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.q    = q[8] ? 8'hFF : q[7:0];

endmodule
`default_nettype wire

// ===== rtl/triangle_raster_gouraud.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_raster_gouraud
// triangle rasterizer with gouraud shading over a packed 32-bit frame store
// ---------------------------------------------------------------------------
// One item is handled at a time. A clear sweeps the frame store one pixel per
// cycle, and the same sweep runs after reset before the first item is taken.
// A read addresses the store in S_READ and takes the data in S_RDWAIT. A draw
// runs all its arithmetic through one shared multiply-accumulate unit and one
// bit-serial divider: each pixel of the clamped bounding box is tested with
// nine products for the edge tests, and each pixel written then takes nine
// products for the colour sums, three nine-step divisions and the store write.
module triangle_raster_gouraud #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [11:0] x0,
  input  wire logic [11:0] y0,
  input  wire logic [11:0] x1,
  input  wire logic [11:0] y1,
  input  wire logic [11:0] x2,
  input  wire logic [11:0] y2,
  input  wire logic [23:0] colour0,
  input  wire logic [23:0] colour1,
  input  wire logic [23:0] colour2,
  input  wire logic [5:0]  pixel_x,
  input  wire logic [5:0]  pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_colour,
  output logic             culled,
  output logic [12:0]      pixels_written
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = trg_pkg::CRD_W;
  localparam int PW    = trg_pkg::PT_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLEAR   = 4'd1;
  localparam logic [3:0] S_READ    = 4'd2;
  localparam logic [3:0] S_RDWAIT  = 4'd3;
  localparam logic [3:0] S_TOTAL   = 4'd4;
  localparam logic [3:0] S_SETUP   = 4'd5;
  localparam logic [3:0] S_AREA    = 4'd6;
  localparam logic [3:0] S_TEST    = 4'd7;
  localparam logic [3:0] S_COL     = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;
  localparam logic [3:0] S_DIVWAIT = 4'd10;
  localparam logic [3:0] S_WRITE   = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0] state;

  // configuration
  logic [CW-1:0] active_width;
  logic [CW-1:0] active_height;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {25'd0, active_height} : {25'd0, active_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= 7'd64;
      active_height <= 7'd64;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        active_height <= pwdata[CW-1:0];
      end else begin
        active_width <= pwdata[CW-1:0];
      end
    end
  end

  // captured item
  logic [1:0]  act;
  logic [11:0] vx0, vy0, vx1, vy1, vx2, vy2;
  logic [23:0] col0, col1, col2;
  logic [5:0]  pix_x, pix_y;

  // draw state
  logic [CW-1:0] px, py, xmin, xmax, ymax;
  logic [1:0]    e, t, dch;
  logic          clr_reply;
  logic [AW-1:0] clr_addr;

  logic signed [trg_pkg::PROD_W-1:0] acc, prod, acc_sum, acc_neg;
  logic signed [trg_pkg::AREA_W-1:0] opa;
  logic signed [trg_pkg::OPB_W-1:0]  opb;
  logic signed [trg_pkg::AREA_W-1:0] w0, w1, w2;
  logic [trg_pkg::DEN_W-1:0]         den;
  logic [trg_pkg::NUM_W-1:0]         num_r, num_g, num_b;
  logic [7:0]                        q_r, q_g;

  // results
  logic [31:0]               res_colour;
  logic                      res_culled;
  logic [trg_pkg::CNT_W-1:0] res_count;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  // divider
  trg_pkg::div_req_t div_req;
  trg_pkg::div_rsp_t div_rsp;

  logic out_load;

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // point select: 0..2 vertices, 3 current pixel
  function automatic logic [2*PW-1:0] pt_sel(
    input logic [1:0]  idx,
    input logic [11:0] ax0, input logic [11:0] ay0,
    input logic [11:0] ax1, input logic [11:0] ay1,
    input logic [11:0] ax2, input logic [11:0] ay2,
    input logic [CW-1:0] cx, input logic [CW-1:0] cy
  );
    logic [2*PW-1:0] r;
    case (idx)
      2'd0:    r = {ax0[11], ax0, ay0[11], ay0};
      2'd1:    r = {ax1[11], ax1, ay1[11], ay1};
      2'd2:    r = {ax2[11], ax2, ay2[11], ay2};
      default: r = {{(PW-CW){1'b0}}, cx, {(PW-CW){1'b0}}, cy};
    endcase
    return r;
  endfunction

  // triangle corners for the current edge function and term endpoints
  logic [1:0]          ia, ib, ic, i_f, i_s;
  logic [2*PW-1:0]     pf, ps;
  logic signed [PW-1:0] dx, sy;
  logic [7:0]          cbyte;
  logic [23:0]         csel;

  always_comb begin
    if (state == S_TOTAL) begin
      ia = 2'd0; ib = 2'd1; ic = 2'd2;
    end else begin
      ia = 2'd3;
      case (e)
        2'd0:    begin ib = 2'd1; ic = 2'd2; end
        2'd1:    begin ib = 2'd2; ic = 2'd0; end
        default: begin ib = 2'd0; ic = 2'd1; end
      endcase
    end
    case (t)
      2'd0:    begin i_f = ia; i_s = ib; end
      2'd1:    begin i_f = ib; i_s = ic; end
      default: begin i_f = ic; i_s = ia; end
    endcase
    pf = pt_sel(i_f, vx0, vy0, vx1, vy1, vx2, vy2, px, py);
    ps = pt_sel(i_s, vx0, vy0, vx1, vy1, vx2, vy2, px, py);
    dx = $signed(ps[2*PW-1:PW]) - $signed(pf[2*PW-1:PW]);
    sy = $signed(ps[PW-1:0]) + $signed(pf[PW-1:0]);
    case (t)
      2'd0:    csel = col0;
      2'd1:    csel = col1;
      default: csel = col2;
    endcase
    case (e)
      2'd0:    cbyte = csel[7:0];
      2'd1:    cbyte = csel[15:8];
      default: cbyte = csel[23:16];
    endcase
    if (state == S_COL) begin
      case (t)
        2'd0:    opa = w0;
        2'd1:    opa = w1;
        default: opa = w2;
      endcase
      opb = {{(trg_pkg::OPB_W-8){1'b0}}, cbyte};
    end else begin
      opa = {{(trg_pkg::AREA_W-PW){dx[PW-1]}}, dx};
      opb = {sy[PW-1], sy};
    end
  end

  assign prod    = opa * opb;
  assign acc_sum = acc + prod;
  assign acc_neg = -acc_sum;

  // clamped bounding box
  logic [CW-1:0]       wlim, hlim, bx_min, bx_max, by_min, by_max;
  logic signed [PW-1:0] sw, sh, mnx, mxx, mny, mxy;

  always_comb begin
    wlim = (int'(active_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : active_width;
    hlim = (int'(active_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : active_height;
    sw = $signed({{(PW-CW){1'b0}}, wlim});
    sh = $signed({{(PW-CW){1'b0}}, hlim});
    mnx = sw; mxx = '0; mny = sh; mxy = '0;
    if ($signed({vx0[11], vx0}) < mnx) mnx = $signed({vx0[11], vx0});
    if ($signed({vx1[11], vx1}) < mnx) mnx = $signed({vx1[11], vx1});
    if ($signed({vx2[11], vx2}) < mnx) mnx = $signed({vx2[11], vx2});
    if ($signed({vx0[11], vx0}) > mxx) mxx = $signed({vx0[11], vx0});
    if ($signed({vx1[11], vx1}) > mxx) mxx = $signed({vx1[11], vx1});
    if ($signed({vx2[11], vx2}) > mxx) mxx = $signed({vx2[11], vx2});
    if ($signed({vy0[11], vy0}) < mny) mny = $signed({vy0[11], vy0});
    if ($signed({vy1[11], vy1}) < mny) mny = $signed({vy1[11], vy1});
    if ($signed({vy2[11], vy2}) < mny) mny = $signed({vy2[11], vy2});
    if ($signed({vy0[11], vy0}) > mxy) mxy = $signed({vy0[11], vy0});
    if ($signed({vy1[11], vy1}) > mxy) mxy = $signed({vy1[11], vy1});
    if ($signed({vy2[11], vy2}) > mxy) mxy = $signed({vy2[11], vy2});
    if (mnx < 0) mnx = '0;
    if (mny < 0) mny = '0;
    if (mxx > sw) mxx = sw;
    if (mxy > sh) mxy = sh;
    bx_min = mnx[CW-1:0];
    bx_max = mxx[CW-1:0];
    by_min = mny[CW-1:0];
    by_max = mxy[CW-1:0];
  end

  // pixel walk
  logic [CW:0] px_inc, py_inc;
  logic        last_x, last_px;

  assign px_inc  = {1'b0, px} + 1'b1;
  assign py_inc  = {1'b0, py} + 1'b1;
  assign last_x  = px_inc >= {1'b0, xmax};
  assign last_px = last_x && (py_inc >= {1'b0, ymax});

  logic [AW-1:0] pix_addr, rd_addr;
  logic          rd_ok;

  assign pix_addr = AW'(int'(py) * MAX_WIDTH + int'(px));
  assign rd_addr  = AW'(int'(pix_y) * MAX_WIDTH + int'(pix_x));
  assign rd_ok    = (int'(pix_x) < MAX_WIDTH) && (int'(pix_y) < MAX_HEIGHT);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rd_addr;
    ram_wdata = trg_pkg::BLACK_PIXEL;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = pix_addr;
        ram_wdata = {8'h01, div_rsp.q, q_g, q_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start = (state == S_DIV);
    div_req.den   = den;
    case (dch)
      2'd0:    div_req.num = num_r;
      2'd1:    div_req.num = num_g;
      default: div_req.num = num_b;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_reply <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_colour <= '0;
            res_culled <= 1'b0;
            res_count  <= '0;
            case (action)
              trg_pkg::ACT_CLEAR: begin
                state     <= S_CLEAR;
                clr_reply <= 1'b1;
                clr_addr  <= '0;
              end
              trg_pkg::ACT_DRAW: begin
                state <= S_TOTAL;
                acc   <= '0;
                t     <= 2'd0;
              end
              trg_pkg::ACT_READ: state <= S_READ;
              default:           state <= S_DONE;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_READ: state <= S_RDWAIT;
        S_RDWAIT: begin
          if (rd_ok) begin
            res_colour <= ram_rdata;
          end
          state <= S_DONE;
        end
        S_TOTAL: begin
          acc <= acc_sum;
          t   <= t + 2'd1;
          if (t == 2'd2) begin
            if (!acc_sum[trg_pkg::AREA_W-1] && acc_sum[trg_pkg::AREA_W-1:0] != '0
                || acc_sum[trg_pkg::AREA_W-1:0] == '0) begin
              res_culled <= 1'b1;
              state      <= S_DONE;
            end else begin
              den   <= acc_neg[trg_pkg::DEN_W-1:0];
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          xmin <= bx_min;
          xmax <= bx_max;
          ymax <= by_max;
          px   <= bx_min;
          py   <= by_min;
          acc  <= '0;
          e    <= 2'd0;
          t    <= 2'd0;
          if (bx_min >= bx_max || by_min >= by_max) begin
            state <= S_DONE;
          end else begin
            state <= S_AREA;
          end
        end
        S_AREA: begin
          if (t == 2'd2) begin
            acc <= '0;
            t   <= 2'd0;
            e   <= e + 2'd1;
            case (e)
              2'd0:    w0 <= acc_neg[trg_pkg::AREA_W-1:0];
              2'd1:    w1 <= acc_neg[trg_pkg::AREA_W-1:0];
              default: w2 <= acc_neg[trg_pkg::AREA_W-1:0];
            endcase
            if (e == 2'd2) begin
              state <= S_TEST;
            end
          end else begin
            acc <= acc_sum;
            t   <= t + 2'd1;
          end
        end
        S_TEST: begin
          e   <= 2'd0;
          t   <= 2'd0;
          acc <= '0;
          if (w0[trg_pkg::AREA_W-1] || w1[trg_pkg::AREA_W-1] || w2[trg_pkg::AREA_W-1]) begin
            if (last_px) begin
              state <= S_DONE;
            end else begin
              state <= S_AREA;
              if (last_x) begin
                px <= xmin;
                py <= py_inc[CW-1:0];
              end else begin
                px <= px_inc[CW-1:0];
              end
            end
          end else begin
            state <= S_COL;
          end
        end
        S_COL: begin
          if (t == 2'd2) begin
            acc <= '0;
            t   <= 2'd0;
            e   <= e + 2'd1;
            case (e)
              2'd0:    num_r <= acc_sum[trg_pkg::NUM_W-1:0];
              2'd1:    num_g <= acc_sum[trg_pkg::NUM_W-1:0];
              default: num_b <= acc_sum[trg_pkg::NUM_W-1:0];
            endcase
            if (e == 2'd2) begin
              dch   <= 2'd0;
              state <= S_DIV;
            end
          end else begin
            acc <= acc_sum;
            t   <= t + 2'd1;
          end
        end
        S_DIV: state <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (div_rsp.done) begin
            case (dch)
              2'd0:    begin q_r <= div_rsp.q; state <= S_DIV; end
              2'd1:    begin q_g <= div_rsp.q; state <= S_DIV; end
              default: state <= S_WRITE;
            endcase
            if (dch != 2'd2) begin
              dch <= dch + 2'd1;
            end
          end
        end
        S_WRITE: begin
          if (res_count != trg_pkg::CNT_MAX) begin
            res_count <= res_count + 1'b1;
          end
          e   <= 2'd0;
          t   <= 2'd0;
          acc <= '0;
          if (last_px) begin
            state <= S_DONE;
          end else begin
            state <= S_AREA;
            if (last_x) begin
              px <= xmin;
              py <= py_inc[CW-1:0];
            end else begin
              px <= px_inc[CW-1:0];
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act   <= action;
      vx0   <= x0;
      vy0   <= y0;
      vx1   <= x1;
      vy1   <= y1;
      vx2   <= x2;
      vy2   <= y2;
      col0  <= colour0;
      col1  <= colour1;
      col2  <= colour2;
      pix_x <= pixel_x;
      pix_y <= pixel_y;
    end
    if (out_load) begin
      read_colour    <= (act == trg_pkg::ACT_READ) ? res_colour : 32'd0;
      culled         <= res_culled;
      pixels_written <= res_count;
    end
  end

  trg_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  trg_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

endmodule
`default_nettype wire
